>>> rtl/blma_pkg.sv
// Package: shared constants of the line-map accumulator.
`timescale 1ns / 1ps
package blma_pkg;
    localparam int MAX_CHANNELS_D   = 4;
    localparam int MAX_HALF_WIDTH_D = 512;
    localparam int MAX_RECORDS_D    = 64;

    localparam logic [1:0] KIND_ACC  = 2'd0;
    localparam logic [1:0] KIND_IGN  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [2:0] REG_CH_COUNT = 3'd0;
    localparam logic [2:0] REG_TWO_WAY  = 3'd1;
    localparam logic [2:0] REG_HALF_W   = 3'd2;
    localparam logic [2:0] REG_IGNORE   = 3'd3;
    localparam logic [2:0] REG_RPS      = 3'd4;
    localparam logic [2:0] REG_OFFSET   = 3'd5;
    localparam logic [2:0] REG_GAIN     = 3'd6;
    localparam logic [2:0] REG_AVG      = 3'd7;

    localparam int CFG_W = 24;
    localparam int CLAMP_MAX = 16383;
endpackage

>>> rtl/bidirectional_line_map_accumulator.sv
// Top level of the bidirectional line-map accumulator.
//   channel   | dir | tdata (low bit up)                 | tuser
//   s_axis    | in  | sample[15:0] rd_ch rd_row rd_col    | op
//   m_axis    | out | channel row column value done      | kind
//   cfg       | in  | write enable, index, 24-bit data    | -
// A sample goes through a multiply, a 14-step restoring divider and a memory
// read-modify-write; reads and ignored samples go straight to output. The back end
// holds one item at a time. After reset a clearing pass over all 2^18 memory words
// runs before the first item is taken. One front stage decouples input and back end.
`timescale 1ns / 1ps
module bidirectional_line_map_accumulator
    import blma_pkg::*;
#(
    parameter int MAX_CHANNELS   = MAX_CHANNELS_D,
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_D,
    parameter int MAX_RECORDS    = MAX_RECORDS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // sample, read_channel, read_row, read_column
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // channel, row, column, value, record_done
    output logic [1:0]  m_axis_tuser,   // kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);
    logic [2:0]  r_ch_count;
    logic        r_two_way;
    logic [9:0]  r_half_w, r_ignore;
    logic [6:0]  r_rps;
    logic [17:0] r_offset;
    logic [23:0] r_gain;
    logic [15:0] r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_count <= 3'd1; r_two_way <= 1'b1; r_half_w <= 10'd256;
            r_ignore <= 10'd2; r_rps <= 7'd64; r_offset <= '0;
            r_gain <= 24'd16384; r_avg <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CH_COUNT: r_ch_count <= i_cfg_data[2:0];
                REG_TWO_WAY:  r_two_way  <= i_cfg_data[0];
                REG_HALF_W:   r_half_w   <= i_cfg_data[9:0];
                REG_IGNORE:   r_ignore   <= i_cfg_data[9:0];
                REG_RPS:      r_rps      <= i_cfg_data[6:0];
                REG_OFFSET:   r_offset   <= i_cfg_data[17:0];
                REG_GAIN:     r_gain     <= i_cfg_data[23:0];
                REG_AVG:      r_avg      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic        f_valid, f_ready, f_done, b_busy, f_in_ready;
    logic [1:0]  f_kind, f_ch;
    logic [6:0]  f_row;
    logic [8:0]  f_col;
    logic [15:0] f_sample;
    logic [1:0]  b_ch;
    logic [6:0]  b_row;
    logic [8:0]  b_col;
    logic [15:0] b_value;
    logic        b_done;

    blma_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
                 .MAX_RECORDS(MAX_RECORDS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid && !b_busy), .o_ready(f_in_ready),
        .i_op(s_axis_tuser), .i_sample(s_axis_tdata[15:0]),
        .i_rd_ch(s_axis_tdata[17:16]), .i_rd_row(s_axis_tdata[24:18]),
        .i_rd_col(s_axis_tdata[33:25]),
        .i_ch_count(r_ch_count), .i_two_way(r_two_way), .i_half_width(r_half_w),
        .i_ignore(r_ignore), .i_rps(r_rps),
        .o_valid(f_valid), .i_ready(f_ready), .o_kind(f_kind), .o_ch(f_ch),
        .o_row(f_row), .o_col(f_col), .o_sample(f_sample), .o_done(f_done)
    );

    blma_back #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
                .MAX_RECORDS(MAX_RECORDS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_kind(f_kind), .i_ch(f_ch),
        .i_row(f_row), .i_col(f_col), .i_sample(f_sample), .i_done(f_done),
        .i_offset(r_offset), .i_gain(r_gain), .i_avg(r_avg),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_kind(m_axis_tuser),
        .o_ch(b_ch), .o_row(b_row), .o_col(b_col), .o_value(b_value),
        .o_done(b_done), .o_busy(b_busy)
    );

    assign s_axis_tready = f_in_ready && !b_busy;
    assign m_axis_tdata = {5'd0, b_done, b_value, b_col, b_row, b_ch};
endmodule

>>> rtl/blma_front.sv
// Front end: tracks sample position, classifies samples and forms memory addresses.
`timescale 1ns / 1ps
module blma_front
    import blma_pkg::*;
#(
    parameter int MAX_CHANNELS   = MAX_CHANNELS_D,
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_D,
    parameter int MAX_RECORDS    = MAX_RECORDS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_sample,
    input  logic [1:0]  i_rd_ch,
    input  logic [6:0]  i_rd_row,
    input  logic [8:0]  i_rd_col,
    input  logic [2:0]  i_ch_count,
    input  logic        i_two_way,
    input  logic [9:0]  i_half_width,
    input  logic [9:0]  i_ignore,
    input  logic [6:0]  i_rps,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_ch,
    output logic [6:0]  o_row,
    output logic [8:0]  o_col,
    output logic [15:0] o_sample,
    output logic        o_done
);
    logic [12:0] r_pos, n_pos;
    logic [5:0]  r_rec, n_rec;
    logic        r_valid;
    logic [1:0]  r_kind, n_kind, r_ch, n_ch;
    logic [6:0]  r_row, n_row;
    logic [8:0]  r_col, n_col;
    logic [15:0] r_sample;
    logic        r_done, n_done;

    logic        ch_ok;
    logic [12:0] pixel;
    logic [1:0]  sch;
    logic [10:0] h;
    logic [11:0] ppr;
    logic [13:0] len;
    logic [6:0]  rps_eff;
    logic [5:0]  ridx;
    logic        in_rng;

    assign o_ready = !r_valid || i_ready;
    wire take = i_valid && o_ready;

    always_comb begin
        ch_ok = (i_ch_count == 3'd1) || (i_ch_count == 3'd2) || (i_ch_count == 3'd4);
        case (i_ch_count)
            3'd2: begin pixel = {1'b0, r_pos[12:1]}; sch = {1'b0, r_pos[0]}; end
            3'd4: begin pixel = {2'b0, r_pos[12:2]}; sch = r_pos[1:0]; end
            default: begin pixel = r_pos; sch = 2'd0; end
        endcase
        h = (i_half_width > 10'(MAX_HALF_WIDTH)) ? 11'(MAX_HALF_WIDTH)
                                                 : {1'b0, i_half_width};
        ppr = {h, 1'b0} + {2'b0, i_ignore};
        case (i_ch_count)
            3'd2: len = (ppr == 12'd0) ? 14'd2 : {1'b0, ppr, 1'b0};
            3'd4: len = (ppr == 12'd0) ? 14'd4 : {ppr, 2'b0};
            default: len = (ppr == 12'd0) ? 14'd1 : {2'b0, ppr};
        endcase
        rps_eff = (i_rps == 7'd0) ? 7'd1 :
                  ((i_rps > 7'(MAX_RECORDS)) ? 7'(MAX_RECORDS) : i_rps);
        ridx = ({1'b0, r_rec} < 7'(MAX_RECORDS)) ? r_rec : 6'd0;
        in_rng = ({5'b0, i_rd_ch} < 7'(MAX_CHANNELS)) &&
                 ({1'b0, i_rd_row} < 8'(2 * MAX_RECORDS)) &&
                 ({1'b0, i_rd_col} < 10'(MAX_HALF_WIDTH));

        n_pos = r_pos; n_rec = r_rec;
        n_kind = KIND_IGN; n_ch = 2'd0; n_row = 7'd0; n_col = 9'd0; n_done = 1'b0;
        if (i_op) begin
            n_ch = i_rd_ch; n_row = i_rd_row; n_col = i_rd_col;
            n_kind = in_rng ? KIND_READ : KIND_BAD;
        end else if (ch_ok) begin
            n_ch = sch;
            if (pixel >= 13'd1 && pixel <= {2'b0, h}) begin
                n_kind = KIND_ACC;
                n_col = 9'(pixel - 13'd1);
                n_row = i_two_way ? {ridx, 1'b0} : {1'b0, ridx};
            end else if (i_two_way && pixel >= {2'b0, h} + 13'd2 &&
                         pixel <= {1'b0, h, 1'b0} + 13'd1) begin
                n_kind = KIND_ACC;
                n_col = 9'({1'b0, h, 1'b0} + 13'd1 - pixel);
                n_row = {ridx, 1'b1};
            end
            if ({1'b0, r_pos} + 14'd1 >= len) begin
                n_done = 1'b1;
                n_pos = 13'd0;
                n_rec = ({1'b0, ridx} + 7'd1 >= rps_eff) ? 6'd0 : ridx + 6'd1;
            end else begin
                n_pos = r_pos + 13'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_rec <= '0; r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pos <= n_pos; r_rec <= n_rec; r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= n_kind; r_ch <= n_ch; r_row <= n_row; r_col <= n_col;
            r_sample <= i_sample; r_done <= n_done;
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_ch = r_ch;
    assign o_row = r_row;
    assign o_col = r_col;
    assign o_sample = r_sample;
    assign o_done = r_done;
endmodule

>>> rtl/blma_back.sv
// Back end: maps samples, divides, read-modify-writes the image memory, clears on read.
`timescale 1ns / 1ps
module blma_back
    import blma_pkg::*;
#(
    parameter int MAX_CHANNELS   = MAX_CHANNELS_D,
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_D,
    parameter int MAX_RECORDS    = MAX_RECORDS_D,
    parameter int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int ROW_W = $clog2(2 * MAX_RECORDS),
    parameter int COL_W = $clog2(MAX_HALF_WIDTH)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_ch,
    input  logic [6:0]  i_row,
    input  logic [8:0]  i_col,
    input  logic [15:0] i_sample,
    input  logic        i_done,
    input  logic [17:0] i_offset,
    input  logic [23:0] i_gain,
    input  logic [15:0] i_avg,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_ch,
    output logic [6:0]  o_row,
    output logic [8:0]  o_col,
    output logic [15:0] o_value,
    output logic        o_done,
    output logic        o_busy
);
    localparam int AW    = CH_W + ROW_W + COL_W;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_WR    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state      r_state;
    logic [AW-1:0] r_clr;
    logic [15:0] mem [DEPTH];
    logic [15:0] r_rd;
    logic [1:0]  r_kind, r_ch;
    logic [6:0]  r_row;
    logic [8:0]  r_col;
    logic        r_done;
    logic [15:0] r_sample;
    logic [41:0] r_prod;
    logic [13:0] r_rem;
    logic [13:0] r_quo;
    logic [3:0]  r_cnt;
    logic [15:0] r_value;

    logic [AW-1:0] addr;
    logic [18:0]   diff;
    logic [15:0]   avg;
    logic [13:0]   clamp;
    logic [15:0]   trial;

    assign addr = {i_ch[CH_W-1:0], i_row[ROW_W-1:0], i_col[COL_W-1:0]};
    wire [AW-1:0] haddr = {r_ch[CH_W-1:0], r_row[ROW_W-1:0], r_col[COL_W-1:0]};
    assign avg = (i_avg == 16'd0) ? 16'd1 : i_avg;
    assign diff = {3'b0, r_sample} - {i_offset[17], i_offset};
    assign clamp = (r_prod[41:16] > 26'(CLAMP_MAX)) ? 14'(CLAMP_MAX) : r_prod[29:16];
    assign trial = {1'b0, r_rem, r_quo[13]} - {2'b0, avg[13:0]};

    assign o_ready = (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE) && (r_state != S_OUT);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) r_state <= (i_kind == KIND_ACC) ? S_MUL : S_OUT;
                S_MUL:  r_state <= S_DIV;
                S_DIV:  if (r_cnt == 4'd14) r_state <= S_WR;
                S_WR:   r_state <= S_OUT;
                S_OUT:  if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // multiplier output registered; divider restores one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind <= i_kind; r_ch <= i_ch; r_row <= i_row; r_col <= i_col;
                r_done <= i_done; r_sample <= i_sample;
                if (i_valid && (i_kind == KIND_ACC || i_kind == KIND_READ)) r_rd <= mem[addr];
                else r_rd <= 16'd0;
                r_value <= 16'd0;
            end
            S_MUL: begin
                r_prod <= diff[18] || diff == 19'd0 ? 42'd0 : diff[17:0] * i_gain;
                r_cnt <= 4'd0;
            end
            S_DIV: begin
                if (r_cnt == 4'd0) begin
                    r_quo <= clamp; r_rem <= 14'd0; r_cnt <= 4'd1;
                end else begin
                    if (avg[15:14] == 2'd0 && !trial[15]) begin
                        r_rem <= trial[13:0]; r_quo <= {r_quo[12:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[12:0], r_quo[13]}; r_quo <= {r_quo[12:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
            end
            S_WR: r_value <= r_rd + {2'b0, r_quo};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) mem[r_clr] <= 16'd0;
        else if (r_state == S_WR) mem[haddr] <= r_rd + {2'b0, r_quo};
        else if (r_state == S_OUT && i_ready && r_kind == KIND_READ) mem[haddr] <= 16'd0;
    end

    assign o_kind  = r_kind;
    assign o_ch    = r_ch;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_value = (r_kind == KIND_READ) ? r_rd : r_value;
    assign o_done  = r_done;
endmodule

>>> rtl/blma_checker.sv
// Port-level assertions for the line-map accumulator, bound to the top level.
`timescale 1ns / 1ps
module blma_checker
    import blma_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_ign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_IGN |-> m_axis_tdata[33:2] == 32'd0)
        else $error("ignored result carries data");
    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_READ || m_axis_tuser == KIND_BAD)
        |-> !m_axis_tdata[34])
        else $error("read result flags record end");
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_BAD |-> m_axis_tdata[33:18] == 16'd0)
        else $error("invalid read returns data");
endmodule

bind bidirectional_line_map_accumulator blma_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

>>> dv/bidirectional_line_map_accumulator_tb.sv
// Testbench: directed table and randomized phases checked against a behavioral line-map predictor.
`timescale 1ns / 1ps
module bidirectional_line_map_accumulator_tb;
    import blma_pkg::*;

    localparam int ROWS_N     = 2 * MAX_RECORDS_D;
    localparam int WDOG_LIMIT = 1000000;  // covers the clearing pass after reset
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 54;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  chan;
        logic [6:0]  row;
        logic [8:0]  col;
        logic [15:0] value;
        logic        done;
    } pix_result_t;

    typedef struct {
        logic        op;
        logic [15:0] sample;
        logic [1:0]  rch;
        logic [6:0]  rrow;
        logic [8:0]  rcol;
        bit          fixed;     // expected result typed in below
        pix_result_t res;
    } stim_row_t;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = REG_CH_COUNT;
    logic [CFG_W-1:0] i_cfg_data = '0;

    bidirectional_line_map_accumulator i_dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [2:0]  r_chans;
    logic        r_two_way;
    logic [9:0]  r_half_w;
    logic [9:0]  r_ignore;
    logic [6:0]  r_rps;
    logic [17:0] r_offset;
    logic [23:0] r_gain;
    logic [15:0] r_avg;
    logic [12:0] scan_pos;
    logic [5:0]  rec_idx;
    logic [15:0] image_mem [int];
    int          touched_addrs[$];

    pix_result_t pending_results[$];
    int  fail_cnt = 0, wdog = 0;
    int  n_acc = 0, n_ign = 0, n_read = 0, n_done = 0;
    bit  rx_no_stall = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    function automatic logic [15:0] map_code(input logic [15:0] raw);
        longint off, d, v;
        int unsigned divisor;
        off = longint'($signed(r_offset));
        divisor = (r_avg == 0) ? 1 : r_avg;
        d = longint'(raw) - off;
        if (d <= 0) return 16'd0;
        v = (d * longint'(r_gain)) >>> 16;
        if (v > CLAMP_MAX) v = CLAMP_MAX;
        return 16'(int'(v) / divisor);
    endfunction

    function automatic int mem_addr(input int ch, input int row, input int col);
        return (ch * ROWS_N + row) * MAX_HALF_WIDTH_D + col;
    endfunction

    function automatic pix_result_t predict_pixel(input logic op, input logic [15:0] smp,
            input logic [1:0] rch, input logic [6:0] rrow, input logic [8:0] rcol);
        pix_result_t r;
        int n, h, ppr, len, rps, pixel, ridx, a;
        bit keep;
        r = '0;
        r.kind = KIND_IGN;
        if (op) begin
            a = mem_addr(rch, rrow, rcol);
            r.chan = rch; r.row = rrow; r.col = rcol;
            r.kind = KIND_READ;
            r.value = image_mem.exists(a) ? image_mem[a] : 16'd0;
            image_mem[a] = 16'd0;
        end else if (r_chans == 1 || r_chans == 2 || r_chans == 4) begin
            n = r_chans;
            h = (r_half_w > MAX_HALF_WIDTH_D) ? MAX_HALF_WIDTH_D : r_half_w;
            ppr = 2 * h + r_ignore;
            len = (ppr != 0 ? ppr : 1) * n;
            rps = (r_rps == 0) ? 1 : (r_rps > MAX_RECORDS_D ? MAX_RECORDS_D : r_rps);
            pixel = scan_pos / n;
            ridx = rec_idx;
            keep = 0;
            r.chan = 2'(scan_pos % n);
            if (pixel >= 1 && pixel <= h) begin
                keep = 1;
                r.col = 9'(pixel - 1);
                r.row = 7'(r_two_way ? 2 * ridx : ridx);
            end else if (r_two_way && pixel >= h + 2 && pixel <= 2 * h + 1) begin
                keep = 1;
                r.col = 9'(2 * h + 1 - pixel);
                r.row = 7'(2 * ridx + 1);
            end
            if (keep) begin
                a = mem_addr(r.chan, r.row, r.col);
                r.value = (image_mem.exists(a) ? image_mem[a] : 16'd0) + map_code(smp);
                image_mem[a] = r.value;
                touched_addrs.push_back(a);
                r.kind = KIND_ACC;
            end
            if (int'(scan_pos) + 1 >= len) begin
                r.done = 1;
                scan_pos = '0;
                rec_idx = (ridx + 1 >= rps) ? 6'd0 : 6'(ridx + 1);
            end else begin
                scan_pos = scan_pos + 13'd1;
            end
        end
        return r;
    endfunction

    // output checker
    always @(posedge i_clk) begin
        pix_result_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.kind  = m_axis_tuser;
            got.chan  = m_axis_tdata[1:0];
            got.row   = m_axis_tdata[8:2];
            got.col   = m_axis_tdata[17:9];
            got.value = m_axis_tdata[33:18];
            got.done  = m_axis_tdata[34];
            if (pending_results.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("kind %0d exp %0d", got.kind, want.kind));
                if (got.chan != want.chan)
                    report($sformatf("channel %0d exp %0d", got.chan, want.chan));
                if (got.row != want.row)
                    report($sformatf("row %0d exp %0d", got.row, want.row));
                if (got.col != want.col)
                    report($sformatf("column %0d exp %0d", got.col, want.col));
                if (got.value != want.value)
                    report($sformatf("value %0d exp %0d", got.value, want.value));
                if (got.done != want.done)
                    report($sformatf("record_done %0d exp %0d", got.done, want.done));
            end
        end
    end

    // watchdog: cycles with no transfer on either stream and no config write
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired: no transfer for %0d cycles", WDOG_LIMIT);
            $display("bidirectional_line_map_accumulator_tb failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver backpressure
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_no_stall || pick_gap() == 0) begin
                m_axis_tready = 1;
            end else begin
                m_axis_tready = 0;
                repeat (pick_gap()) @(negedge i_clk);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic op, input logic [15:0] smp, input logic [1:0] rch,
            input logic [6:0] rrow, input logic [8:0] rcol, input bit no_gap,
            input bit fixed, input pix_result_t fixed_res);
        int gap;
        pix_result_t pr;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser  = op;
        s_axis_tdata  = {6'd0, rcol, rrow, rch, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pr = predict_pixel(op, smp, rch, rrow, rcol);
        if (fixed && pr != fixed_res)
            report($sformatf("predictor disagrees with table row (op %0d)", op));
        pending_results.push_back(fixed ? fixed_res : pr);
        case (pr.kind)
            KIND_ACC:  n_acc++;
            KIND_IGN:  n_ign++;
            default:   n_read++;
        endcase
        if (pr.done) n_done++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = val;
        case (idx)
            REG_CH_COUNT: r_chans   = val[2:0];
            REG_TWO_WAY:  r_two_way = val[0];
            REG_HALF_W:   r_half_w  = val[9:0];
            REG_IGNORE:   r_ignore  = val[9:0];
            REG_RPS:      r_rps     = val[6:0];
            REG_OFFSET:   r_offset  = val[17:0];
            REG_GAIN:     r_gain    = val[23:0];
            default:      r_avg     = val[15:0];
        endcase
        @(negedge i_clk);
    endtask

    stim_row_t dir_tab[$];

    task automatic add_row(input logic op, input logic [15:0] smp, input logic [1:0] rch,
            input logic [6:0] rrow, input logic [8:0] rcol, input bit fixed,
            input logic [1:0] kind, input logic [1:0] ch, input logic [6:0] row,
            input logic [8:0] col, input logic [15:0] val, input logic done);
        stim_row_t s;
        s.op = op; s.sample = smp; s.rch = rch; s.rrow = rrow; s.rcol = rcol;
        s.fixed = fixed;
        s.res = '{kind: kind, chan: ch, row: row, col: col, value: val, done: done};
        dir_tab.push_back(s);
    endtask

    initial begin
        int a, phase, sel, idx;
        logic [23:0] cfg_v [8];
        logic [15:0] smp;
        bit quiet;
        r_chans = 1; r_two_way = 1; r_half_w = 256; r_ignore = 2; r_rps = 64;
        r_offset = '0; r_gain = 24'd16384; r_avg = 16'd1;
        scan_pos = '0; rec_idx = '0;

        // directed part under reset settings (1 channel, H 256, two-way)
        add_row(0, 16'hFFFF, 0, 0, 0, 1, KIND_IGN, 0, 0, 0, 0, 0);          // pixel 0 skipped
        add_row(1, 0, 3, 127, 511, 1, KIND_READ, 3, 127, 511, 0, 0);        // far corner, clear
        add_row(0, 16'hFFFF, 0, 0, 0, 1, KIND_ACC, 0, 0, 0, 16383, 0);      // full-scale sample, top code
        add_row(0, 16'h0000, 0, 0, 0, 1, KIND_ACC, 0, 0, 1, 0, 0);          // zero code
        add_row(0, 16'd4, 0, 0, 0, 1, KIND_ACC, 0, 0, 2, 1, 0);             // 4 * 1/4
        add_row(1, 0, 0, 0, 0, 1, KIND_READ, 0, 0, 0, 16383, 0);
        add_row(1, 0, 0, 0, 0, 1, KIND_READ, 0, 0, 0, 0, 0);                // read cleared it
        add_row(1, 0, 0, 0, 2, 1, KIND_READ, 0, 0, 2, 1, 0);
        add_row(0, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 16'h7FFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 2, 64, 256, 0, 0, 0, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].sample, dir_tab[i].rch, dir_tab[i].rrow,
                      dir_tab[i].rcol, 0, dir_tab[i].fixed, dir_tab[i].res);
        drain();

        for (phase = 0; phase < N_PHASES; phase++) begin
            cfg_v[REG_CH_COUNT] = (phase == 3) ? 3 : (phase == 6) ? 0 : (phase == 8) ? 7 :
                                  (phase % 3 == 0) ? 4 : (phase % 3 == 1) ? 1 : 2;
            cfg_v[REG_TWO_WAY]  = (phase % 2 == 0);
            cfg_v[REG_HALF_W]   = (phase == 2) ? 0 : (phase == 4) ? 1023 : (phase == 5) ? 512 :
                                  (phase == 7) ? 1 : $urandom_range(1, 6);
            cfg_v[REG_IGNORE]   = (phase == 2) ? 0 : (phase == 9) ? 1023 :
                                  (phase == 7) ? 1 : $urandom_range(2, 4);
            cfg_v[REG_RPS]      = (phase == 1) ? 0 : (phase == 4) ? 127 : (phase == 5) ? 64 :
                                  $urandom_range(1, 4);
            cfg_v[REG_OFFSET]   = (phase == 1) ? 24'h020000 : (phase == 5) ? 24'h01FFFF :
                                  24'($urandom_range(0, 4000) - 2000) & 24'h3FFFF;
            cfg_v[REG_GAIN]     = (phase == 2) ? 0 : (phase == 4) ? 24'hFFFFFF :
                                  $urandom_range(0, 24'h0FFFFF);
            cfg_v[REG_AVG]      = (phase == 3) ? 0 : (phase == 6) ? 65535 :
                                  $urandom_range(1, 4);
            for (idx = 0; idx < 8; idx++)
                write_reg(3'(idx), cfg_v[idx]);
            i_cfg_we = 0;

            quiet = (phase == 5);
            rx_no_stall = quiet;
            for (int k = 0; k < PHASE_LEN; k++) begin
                // in phase 4 the sender waits out every result once, mid-phase
                if (phase == 4 && k == PHASE_LEN / 2) begin
                    s_axis_tvalid = 0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
                sel = $urandom_range(99);
                smp = 16'($urandom_range(0, 16'hFFFF));
                if (sel < 85) begin
                    send_item(0, smp, 0, 0, 0, quiet, 0, '0);
                end else if (sel < 93 && touched_addrs.size() != 0) begin
                    a = touched_addrs[$urandom_range(0, touched_addrs.size() - 1)];
                    send_item(1, smp, 2'(a / (ROWS_N * MAX_HALF_WIDTH_D)),
                              7'((a / MAX_HALF_WIDTH_D) % ROWS_N), 9'(a % MAX_HALF_WIDTH_D),
                              quiet, 0, '0);
                end else begin
                    send_item(1, smp, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                              9'($urandom_range(0, 511)), quiet, 0, '0);
                end
            end
            drain();
        end

        $display("covered %0d accumulated, %0d ignored samples, %0d reads, %0d record ends",
                 n_acc, n_ign, n_read, n_done);
        $display("%0d setting phases incl. odd channel counts, zero and saturated widths",
                 N_PHASES);
        if (fail_cnt == 0) begin
            $display("bidirectional_line_map_accumulator_tb passed");
        end else begin
            $display("bidirectional_line_map_accumulator_tb failed");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/blma_pkg.sv
rtl/blma_front.sv
rtl/blma_back.sv
rtl/bidirectional_line_map_accumulator.sv
rtl/blma_checker.sv
dv/bidirectional_line_map_accumulator_tb.sv
